@@ hdl/mfbr_pkg.sv @@
// shared types and constants for the marker framed byte receiver
// no dependencies; imported by every module of the block but mfbr_ram
package mfbr_pkg;

	localparam int BUF_BYTES = 64;
	localparam int ADDR_W    = $clog2(BUF_BYTES);
	localparam int CNT_W     = $clog2(BUF_BYTES + 1);
	localparam int RAM_DEPTH = 2 * BUF_BYTES;
	localparam int RAM_AW    = ADDR_W + 1;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int ERR_W     = 32;

	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_ERROR = 1'b1;

	typedef enum logic [2:0] {
		MODE_LOST  = 3'b001,
		MODE_WAIT  = 3'b010,
		MODE_FRAME = 3'b100
	} rx_mode_t;

	typedef struct packed {
		logic              op;
		logic [BYTE_W-1:0] data_byte;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] frame_byte;
		logic              last_byte;
		logic [LEN_W-1:0]  frame_length;
		logic [ERR_W-1:0]  error_count;
	} out_t;

	// one finished frame waiting in a buffer bank
	typedef struct packed {
		logic             bank;
		logic [LEN_W-1:0] len;
		logic [ERR_W-1:0] errs;
	} desc_t;

	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	typedef struct packed {
		logic              we;
		logic [RAM_AW-1:0] addr;
		logic [BYTE_W-1:0] data;
	} ram_wr_t;

	typedef struct packed {
		logic              re;
		logic [RAM_AW-1:0] addr;
	} ram_rd_t;

endpackage

@@ hdl/marker_framed_byte_receiver_unit.sv @@
// Marker framed byte receiver, top level.
// Input queue side: push/full with in_item {op, data_byte}; op selects a
// received byte or a receive error event. A beat is taken when push is high
// and full is low; the front end takes one beat per cycle.
// Result queue side: empty/pop with out_item {frame_byte, last_byte,
// frame_length, error_count}; one beat per payload byte of a closed frame.
// Configuration: cfg_wr_en/cfg_wr_data write the marker byte.
// Bytes go into one of two buffer banks. When a marker closes a frame, its
// bank is handed to the back end through a two entry descriptor queue and
// reception continues in the other bank.
// A closed frame reaches the output through the descriptor queue and the
// back end; beats are paced by the single outstanding ram read.
// full rises only while both banks hold frames not yet read out, so a
// receiver that stops popping backs up into the input side after at most
// two frames. The output beat holds while pop is low.
// Reset: mode lost, byte count and error counter zero, marker byte zero,
// both banks free, no results pending. Buffer contents are not cleared.
// depends on mfbr_pkg, mfbr_ram, mfbr_front, mfbr_desc_q, mfbr_back
module marker_framed_byte_receiver_unit import mfbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_t               in_item,
	output logic              empty,
	input  logic              pop,
	output out_t              out_item,
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data
);

	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [BYTE_W-1:0] ram_rdata;
	rel_t              rel;
	logic              desc_push;
	desc_t             desc_in;
	desc_t             desc_out;
	logic              desc_empty;
	logic              desc_pop;

	mfbr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.rel         (rel),
		.ram_wr      (ram_wr),
		.desc_push   (desc_push),
		.desc        (desc_in)
	);

	mfbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	mfbr_desc_q u_desc_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (desc_push),
		.din    (desc_in),
		.rd     (desc_pop),
		.dout   (desc_out),
		.empty  (desc_empty)
	);

	mfbr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_desc    (desc_out),
		.q_empty   (desc_empty),
		.q_pop     (desc_pop),
		.ram_rd    (ram_rd),
		.ram_rdata (ram_rdata),
		.rel       (rel),
		.empty     (empty),
		.pop       (pop),
		.out_item  (out_item)
	);

endmodule

@@ hdl/mfbr_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mfbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/mfbr_front.sv @@
// front end: takes bytes and error events, runs the framing mode machine,
// stores bytes into the current buffer bank; depends on mfbr_pkg
module mfbr_front import mfbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_t               in_item,
	input  logic              cfg_wr_en,
	input  logic [BYTE_W-1:0] cfg_wr_data,
	input  rel_t              rel,
	output ram_wr_t           ram_wr,
	output logic              desc_push,
	output desc_t             desc
);

	logic [BYTE_W-1:0] marker_q;
	rx_mode_t          mode_q, mode_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
	logic [ERR_W-1:0]  err_q, err_d;
	logic              cur_q, cur_d;
	logic [1:0]        busy_q, busy_d;
	logic              accept;
	logic              emit;

	assign full    = busy_q[cur_q];
	assign accept  = push && !full;
	assign cnt_inc = cnt_q + CNT_W'(1);

	always_comb begin
		mode_d = mode_q;
		cnt_d  = cnt_q;
		err_d  = err_q;
		cur_d  = cur_q;
		busy_d = busy_q;
		emit   = 1'b0;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (accept) begin
			if (in_item.op == OP_ERROR) begin
				err_d = err_q + ERR_W'(1);
				if (mode_q == MODE_FRAME) begin
					mode_d = MODE_LOST;
				end
			end else if (in_item.data_byte == marker_q) begin
				// count before this byte is zero when the marker is alone
				case (mode_q)
					MODE_WAIT: begin
						if (cnt_q == '0) begin
							mode_d = MODE_FRAME;
						end else begin
							err_d  = err_q + ERR_W'(1);
							mode_d = MODE_LOST;
						end
					end
					MODE_FRAME: begin
						if (cnt_q != '0) begin
							emit           = 1'b1;
							mode_d         = MODE_WAIT;
							cur_d          = ~cur_q;
							busy_d[cur_q]  = 1'b1;
						end
					end
					default: begin
						if (cnt_q != '0) begin
							mode_d = MODE_WAIT;
						end else begin
							mode_d = MODE_FRAME;
						end
					end
				endcase
				cnt_d = '0;
			end else if (cnt_inc >= CNT_W'(BUF_BYTES)) begin
				// buffer full with no marker
				err_d  = err_q + ERR_W'(1);
				mode_d = MODE_LOST;
				cnt_d  = '0;
			end else begin
				cnt_d = cnt_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= '0;
			mode_q   <= MODE_LOST;
			cnt_q    <= '0;
			err_q    <= '0;
			cur_q    <= 1'b0;
			busy_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				marker_q <= cfg_wr_data;
			end
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			err_q  <= err_d;
			cur_q  <= cur_d;
			busy_q <= busy_d;
		end
	end

	assign ram_wr.we   = accept && (in_item.op == OP_BYTE);
	assign ram_wr.addr = {cur_q, cnt_q[ADDR_W-1:0]};
	assign ram_wr.data = in_item.data_byte;

	// payload length equals the count before the closing marker
	assign desc_push = emit;
	assign desc.bank = cur_q;
	assign desc.len  = LEN_W'(cnt_q);
	assign desc.errs = err_q;

endmodule

@@ hdl/mfbr_desc_q.sv @@
// two entry queue of finished frame descriptors between front and back
// depends on mfbr_pkg
module mfbr_desc_q import mfbr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  desc_t din,
	input  logic  rd,
	output desc_t dout,
	output logic  empty
);

	desc_t      slot_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] count_q;

	assign empty = (count_q == 2'd0);
	assign dout  = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hdl/mfbr_back.sv @@
// back end: reads a finished frame out of its bank, one beat per payload
// byte, through an output register; depends on mfbr_pkg
module mfbr_back import mfbr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  desc_t             q_desc,
	input  logic              q_empty,
	output logic              q_pop,
	output ram_rd_t           ram_rd,
	input  logic [BYTE_W-1:0] ram_rdata,
	output rel_t              rel,
	output logic              empty,
	input  logic              pop,
	output out_t              out_item
);

	logic              active_q;
	desc_t             cur_q;
	logic [ADDR_W-1:0] idx_q;
	logic              rd_s1;
	logic              last_s1;
	logic [LEN_W-1:0]  len_s1;
	logic [ERR_W-1:0]  errs_s1;
	logic              out_valid_q;
	out_t              out_q;
	logic              pop_fire;
	logic              issue;
	logic              is_last;

	assign pop_fire = pop && out_valid_q;
	// one read in flight at a time, only when the output slot is free on return
	assign issue    = active_q && !rd_s1 && (!out_valid_q || pop_fire);
	assign is_last  = (LEN_W'(idx_q) + LEN_W'(1)) == cur_q.len;
	assign q_pop    = !active_q && !q_empty;

	assign ram_rd.re   = issue;
	assign ram_rd.addr = {cur_q.bank, idx_q};

	assign rel.valid = issue && is_last;
	assign rel.bank  = cur_q.bank;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_desc;
		end
		if (issue) begin
			last_s1 <= is_last;
			len_s1  <= cur_q.len;
			errs_s1 <= cur_q.errs;
		end
		if (rd_s1) begin
			out_q.frame_byte   <= ram_rdata;
			out_q.last_byte    <= last_s1;
			out_q.frame_length <= len_s1;
			out_q.error_count  <= errs_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				active_q <= 1'b1;
				idx_q    <= '0;
			end else if (issue) begin
				idx_q <= idx_q + ADDR_W'(1);
				if (is_last) begin
					active_q <= 1'b0;
				end
			end
			rd_s1 <= issue;
			if (rd_s1) begin
				out_valid_q <= 1'b1;
			end else if (pop_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign out_item = out_q;

endmodule

@@ tb/tb_marker_framed_byte_receiver_unit.sv @@
// self-checking testbench for marker_framed_byte_receiver_unit: a clocked driver and monitor
// around the block, with an in-bench predictor of frame extraction and error counting
// depends on mfbr_pkg and the marker_framed_byte_receiver_unit rtl
module tb_marker_framed_byte_receiver_unit;
	import mfbr_pkg::*;

	typedef struct {
		in_t beat;
		bit  hold;  // wait for all pending payload before sending this beat
	} feed_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	in_t               in_item = '0;
	logic              empty;
	logic              pop = 1'b0;
	out_t              out_item;
	logic              cfg_wr_en = 1'b0;
	logic [BYTE_W-1:0] cfg_wr_data = '0;

	feed_t       rx_feed[$];
	out_t        payload_due[$];
	int unsigned beats_queued = 0;
	int unsigned beats_taken = 0;
	int unsigned fail_count = 0;
	bit          idle_on = 1'b1;

	// predictor state
	logic [BYTE_W-1:0] marker_val = '0;
	rx_mode_t          link_mode = MODE_LOST;
	logic [6:0]        fill = '0;
	logic [BYTE_W-1:0] shadow_store [BUF_BYTES];
	logic [ERR_W-1:0]  errs_seen = '0;

	marker_framed_byte_receiver_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.in_item     (in_item),
		.empty       (empty),
		.pop         (pop),
		.out_item    (out_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	// update the shadow receiver with one accepted beat, queue any payload it releases
	task automatic absorb_beat(input in_t beat);
		logic [6:0] cnt;
		int         i;
		if (beat.op == OP_ERROR) begin
			errs_seen++;
			if (link_mode == MODE_FRAME)
				link_mode = MODE_LOST;
			return;
		end
		if (fill >= BUF_BYTES)
			fill = '0;
		shadow_store[fill[ADDR_W-1:0]] = beat.data_byte;
		fill++;
		cnt = fill;
		if (beat.data_byte == marker_val) begin
			case (link_mode)
				MODE_WAIT: begin
					if (cnt == 1) begin
						link_mode = MODE_FRAME;
					end else begin
						errs_seen++;
						link_mode = MODE_LOST;
					end
				end
				MODE_FRAME: begin
					if (cnt > 1) begin
						for (i = 0; i < cnt - 1; i++)
							payload_due.push_back('{frame_byte: shadow_store[i],
								last_byte: (i == cnt - 2), frame_length: LEN_W'(cnt - 1),
								error_count: errs_seen});
						link_mode = MODE_WAIT;
					end
				end
				// lost, and the unused code treated as lost
				default: begin
					link_mode = (cnt > 1) ? MODE_WAIT : MODE_FRAME;
				end
			endcase
			fill = '0;
		end else if (cnt >= BUF_BYTES) begin
			errs_seen++;
			link_mode = MODE_LOST;
			fill = '0;
		end
	endtask

	always @(posedge clk) begin : input_driver
		int unsigned idle_left;
		if (arst_n) begin
			if (push && !full) begin
				absorb_beat(in_item);
				beats_taken++;
				idle_left = pick_gap();
			end
			if (push && full) begin
				// hold the beat until taken
			end else if (idle_left != 0) begin
				push <= 1'b0;
				idle_left--;
			end else if (rx_feed.size() != 0
					&& !(rx_feed[0].hold && payload_due.size() != 0)) begin
				push <= 1'b1;
				in_item <= rx_feed[0].beat;
				void'(rx_feed.pop_front());
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		int unsigned stall_left;
		out_t        want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (payload_due.size() == 0) begin
					$error("payload beat with nothing expected: byte %0h", out_item.frame_byte);
					fail_count++;
				end else begin
					want = payload_due.pop_front();
					if (out_item.frame_byte !== want.frame_byte) begin
						$error("frame_byte exp %0h got %0h", want.frame_byte,
							out_item.frame_byte);
						fail_count++;
					end
					if (out_item.last_byte !== want.last_byte) begin
						$error("last_byte exp %0b got %0b", want.last_byte, out_item.last_byte);
						fail_count++;
					end
					if (out_item.frame_length !== want.frame_length) begin
						$error("frame_length exp %0d got %0d", want.frame_length,
							out_item.frame_length);
						fail_count++;
					end
					if (out_item.error_count !== want.error_count) begin
						$error("error_count exp %0d got %0d", want.error_count,
							out_item.error_count);
						fail_count++;
					end
				end
				stall_left = pick_gap();
			end
			if (stall_left != 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic send(input logic op, input logic [BYTE_W-1:0] data, input bit hold = 1'b0);
		feed_t f;
		f.beat.op = op;
		f.beat.data_byte = data;
		f.hold = hold;
		rx_feed.push_back(f);
		beats_queued++;
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do
			b = BYTE_W'($urandom_range(255));
		while (b == marker_val);
		return b;
	endfunction

	// opening marker, payload free of markers, closing marker
	task automatic send_frame(input int len, input bit hold = 1'b0);
		int i;
		send(OP_BYTE, marker_val, hold);
		for (i = 0; i < len; i++)
			send(OP_BYTE, plain_byte());
		send(OP_BYTE, marker_val);
	endtask

	task automatic settle();
		while (beats_taken != beats_queued || payload_due.size() != 0)
			@(posedge clk);
		// tail of non-emitting beats may still be in flight
		repeat (20) @(posedge clk);
	endtask

	task automatic write_marker(input logic [BYTE_W-1:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		marker_val = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned pick;
		int          i;
		stop_at = beats_queued + quota;
		while (beats_queued < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				pick = $urandom_range(99);
				send_frame(pick < 80 ? $urandom_range(8, 1) :
					pick < 95 ? $urandom_range(40, 9) : $urandom_range(63, 62),
					$urandom_range(19) == 0);
			end else if (pick < 80) begin
				repeat ($urandom_range(2, 1)) send(OP_ERROR, BYTE_W'($urandom_range(255)));
			end else if (pick < 90) begin
				repeat ($urandom_range(5, 1))
					send(OP_BYTE, $urandom_range(2) == 0 ? marker_val : plain_byte());
			end else if (pick < 95) begin
				// frame broken by a receive error
				send(OP_BYTE, marker_val);
				repeat ($urandom_range(6)) send(OP_BYTE, plain_byte());
				send(OP_ERROR, BYTE_W'($urandom_range(255)));
				repeat ($urandom_range(3)) send(OP_BYTE, plain_byte());
				send(OP_BYTE, marker_val);
			end else begin
				for (i = 0; i < BUF_BYTES; i++)
					send(OP_BYTE, plain_byte());
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed
		write_marker(8'h7e);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h00);
		send(OP_BYTE, 8'hff);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h55);
		send(OP_ERROR, 8'h00);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'haa);
		send(OP_BYTE, 8'h7e);
		send(OP_ERROR, 8'hff);
		send(OP_BYTE, 8'h12);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h7e);
		send(OP_BYTE, 8'h01);
		send(OP_BYTE, 8'h7e, 1'b1);
		settle();

		// marker in the last slot, then a buffer overflow, then random
		write_marker(8'h00);
		send_frame(63, 1'b1);
		repeat (BUF_BYTES) send(OP_BYTE, plain_byte());
		random_traffic(20);
		settle();

		write_marker(8'hff);
		random_traffic(15);
		settle();

		// back to back on both sides
		idle_on = 1'b0;
		write_marker(BYTE_W'($urandom_range(254, 1)));
		random_traffic(15);
		settle();

		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
